>>> rtl/iprc_pkg.sv
// ----------------------------------------------------------------------------
// iprc_pkg
// Shared types and constants for the IPv4 port redirect classifier.
// ----------------------------------------------------------------------------
package iprc_pkg;

  localparam int ADDRESS_ENTRIES_DEF = 16;
  localparam int PORT_ENTRIES_DEF    = 16;
  localparam int QUEUE_COUNT_DEF     = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_ADDR_WR = 2'd1;
  localparam logic [1:0] OP_PORT_WR = 2'd2;

  localparam logic [1:0] VERDICT_DROP     = 2'd0;
  localparam logic [1:0] VERDICT_PASS     = 2'd1;
  localparam logic [1:0] VERDICT_REDIRECT = 2'd2;

  localparam logic [15:0] ETHER_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP       = 8'd6;
  localparam logic [7:0]  PROTO_UDP       = 8'd17;

  typedef enum logic [1:0] {
    KIND_ADDR_WR,
    KIND_PORT_WR,
    KIND_FRAME
  } iprc_kind_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [3:0]  rx_queue;
    logic [3:0]  entry_index;
    logic [31:0] entry_key;
    logic        entry_valid;
  } iprc_in_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [3:0] target_queue;
  } iprc_out_t;

  // one queued job: a table write or a finished frame summary
  typedef struct packed {
    iprc_kind_t  kind;
    logic        len_ge14;
    logic        len_ge34;
    logic        len_ge42;
    logic        len_ge54;
    logic        is_ipv4;
    logic        ihl_ok;
    logic [31:0] dest_address;
    logic [7:0]  l4_protocol;
    logic [15:0] dest_port;
    logic [3:0]  frame_queue;
    logic [3:0]  entry_index;
    logic [31:0] entry_key;
    logic        entry_valid;
  } iprc_desc_t;

endpackage

>>> rtl/iprc_front.sv
// ----------------------------------------------------------------------------
// iprc_front
// Byte parser: tracks frame offset, captures header fields and emits one
// job per frame end or table write.
// ----------------------------------------------------------------------------
module iprc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_acc,
  input  iprc_pkg::iprc_in_t  item,
  output logic                job_push,
  output iprc_pkg::iprc_desc_t job
);

  localparam logic [5:0] OFF_MAX = 6'd63;

  logic [5:0]  off_r,   off_nxt;
  logic [15:0] ether_r, ether_nxt;
  logic        ihl_r,   ihl_nxt;
  logic [31:0] addr_r,  addr_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] port_r,  port_nxt;
  logic [3:0]  queue_r, queue_nxt;

  logic [15:0] cap_ether;
  logic        cap_ihl;
  logic [31:0] cap_addr;
  logic [7:0]  cap_proto;
  logic [15:0] cap_port;
  logic [3:0]  cap_queue;
  logic [7:0]  b;

  assign b = item.data_byte;

  // fields including the current byte
  always_comb begin
    cap_ether = ether_r;
    cap_ihl   = ihl_r;
    cap_addr  = addr_r;
    cap_proto = proto_r;
    cap_port  = port_r;
    cap_queue = (off_r == 6'd0) ? item.rx_queue : queue_r;
    case (off_r)
      6'd12: cap_ether[15:8]  = b;
      6'd13: cap_ether[7:0]   = b;
      6'd14: cap_ihl          = (b[3:0] == 4'd5);
      6'd23: cap_proto        = b;
      6'd30: cap_addr[7:0]    = b;
      6'd31: cap_addr[15:8]   = b;
      6'd32: cap_addr[23:16]  = b;
      6'd33: cap_addr[31:24]  = b;
      6'd36: cap_port[7:0]    = b;
      6'd37: cap_port[15:8]   = b;
      default: ;
    endcase
  end

  always_comb begin
    off_nxt   = off_r;
    ether_nxt = ether_r;
    ihl_nxt   = ihl_r;
    addr_nxt  = addr_r;
    proto_nxt = proto_r;
    port_nxt  = port_r;
    queue_nxt = queue_r;
    job_push  = 1'b0;

    job              = '0;
    job.kind         = iprc_pkg::KIND_FRAME;
    job.len_ge14     = (off_r >= 6'd13);
    job.len_ge34     = (off_r >= 6'd33);
    job.len_ge42     = (off_r >= 6'd41);
    job.len_ge54     = (off_r >= 6'd53);
    job.is_ipv4      = (cap_ether == iprc_pkg::ETHER_TYPE_IPV4);
    job.ihl_ok       = cap_ihl;
    job.dest_address = cap_addr;
    job.l4_protocol  = cap_proto;
    job.dest_port    = cap_port;
    job.frame_queue  = cap_queue;
    job.entry_index  = item.entry_index;
    job.entry_key    = item.entry_key;
    job.entry_valid  = item.entry_valid;

    if (item_acc) begin
      unique case (item.op)
        iprc_pkg::OP_BYTE: begin
          if (item.last_byte) begin
            job_push  = 1'b1;
            off_nxt   = '0;
            ether_nxt = '0;
            ihl_nxt   = 1'b0;
            addr_nxt  = '0;
            proto_nxt = '0;
            port_nxt  = '0;
            queue_nxt = '0;
          end else begin
            off_nxt   = (off_r == OFF_MAX) ? off_r : off_r + 6'd1;
            ether_nxt = cap_ether;
            ihl_nxt   = cap_ihl;
            addr_nxt  = cap_addr;
            proto_nxt = cap_proto;
            port_nxt  = cap_port;
            queue_nxt = cap_queue;
          end
        end
        iprc_pkg::OP_ADDR_WR: begin
          job_push = 1'b1;
          job.kind = iprc_pkg::KIND_ADDR_WR;
        end
        iprc_pkg::OP_PORT_WR: begin
          job_push = 1'b1;
          job.kind = iprc_pkg::KIND_PORT_WR;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      ether_r <= '0;
      ihl_r   <= 1'b0;
      addr_r  <= '0;
      proto_r <= '0;
      port_r  <= '0;
      queue_r <= '0;
    end else begin
      off_r   <= off_nxt;
      ether_r <= ether_nxt;
      ihl_r   <= ihl_nxt;
      addr_r  <= addr_nxt;
      proto_r <= proto_nxt;
      port_r  <= port_nxt;
      queue_r <= queue_nxt;
    end
  end

endmodule

>>> rtl/iprc_fifo.sv
// ----------------------------------------------------------------------------
// iprc_fifo
// Short job queue between the parser and the classifier.
// ----------------------------------------------------------------------------
module iprc_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  iprc_pkg::iprc_desc_t push_data,
  output logic                 full,
  input  logic                 pop,
  output iprc_pkg::iprc_desc_t head,
  output logic                 empty
);

  localparam int DEPTH = iprc_pkg::QUEUE_DEPTH;
  localparam int PW    = iprc_pkg::QUEUE_PTR_W;
  localparam int CW    = iprc_pkg::QUEUE_CNT_W;

  iprc_pkg::iprc_desc_t entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> rtl/iprc_back.sv
// ----------------------------------------------------------------------------
// iprc_back
// Classifier: owns both match tables, applies table writes in order and
// turns frame summaries into verdicts held in an output register.
// ----------------------------------------------------------------------------
module iprc_back #(
  parameter int ADDRESS_ENTRIES = iprc_pkg::ADDRESS_ENTRIES_DEF,
  parameter int PORT_ENTRIES    = iprc_pkg::PORT_ENTRIES_DEF,
  parameter int QUEUE_COUNT     = iprc_pkg::QUEUE_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_empty,
  input  iprc_pkg::iprc_desc_t job,
  output logic                 job_pop,
  input  logic [15:0]          queue_ready_mask,
  output logic                 out_valid,
  input  logic                 out_stall,
  output iprc_pkg::iprc_out_t  out_data
);

  logic [ADDRESS_ENTRIES-1:0] addr_vld_r;
  logic [31:0]                addr_key_r [ADDRESS_ENTRIES];
  logic [PORT_ENTRIES-1:0]    port_vld_r;
  logic [31:0]                port_key_r [PORT_ENTRIES];

  logic      out_valid_r;
  iprc_pkg::iprc_out_t out_data_r, res;

  logic        is_frame, out_free, addr_hit, port_hit, q_ready;
  logic [31:0] port_key;

  assign is_frame = (job.kind == iprc_pkg::KIND_FRAME);
  assign out_free = !out_valid_r || !out_stall;
  assign job_pop  = !job_empty && (!is_frame || out_free);
  assign port_key = {job.dest_port, 8'h00, job.l4_protocol};

  always_comb begin
    addr_hit = 1'b0;
    for (int i = 0; i < ADDRESS_ENTRIES; i++) begin
      if (addr_vld_r[i] && (addr_key_r[i] == job.dest_address)) begin
        addr_hit = 1'b1;
      end
    end
    port_hit = 1'b0;
    for (int i = 0; i < PORT_ENTRIES; i++) begin
      if (port_vld_r[i] && (port_key_r[i] == port_key)) begin
        port_hit = 1'b1;
      end
    end
  end

  assign q_ready = (int'(job.frame_queue) < QUEUE_COUNT) &&
                   queue_ready_mask[job.frame_queue];

  always_comb begin
    res = '0;
    if (!job.len_ge14) begin
      res.verdict = iprc_pkg::VERDICT_DROP;
    end else if (!job.is_ipv4) begin
      res.verdict = iprc_pkg::VERDICT_PASS;
    end else if (!job.len_ge34 || !job.ihl_ok) begin
      res.verdict = iprc_pkg::VERDICT_DROP;
    end else if (!addr_hit) begin
      res.verdict = iprc_pkg::VERDICT_PASS;
    end else if (job.l4_protocol != iprc_pkg::PROTO_TCP &&
                 job.l4_protocol != iprc_pkg::PROTO_UDP) begin
      res.verdict = iprc_pkg::VERDICT_PASS;
    end else if ((job.l4_protocol == iprc_pkg::PROTO_TCP && !job.len_ge54) ||
                 (job.l4_protocol == iprc_pkg::PROTO_UDP && !job.len_ge42)) begin
      res.verdict = iprc_pkg::VERDICT_DROP;
    end else if (!port_hit) begin
      res.verdict = iprc_pkg::VERDICT_PASS;
    end else if (q_ready) begin
      res.verdict      = iprc_pkg::VERDICT_REDIRECT;
      res.target_queue = job.frame_queue;
    end else begin
      res.verdict = iprc_pkg::VERDICT_DROP;
    end
  end

  // table writes; slots beyond the table size are never selected
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_vld_r <= '0;
      port_vld_r <= '0;
    end else if (job_pop) begin
      for (int i = 0; i < ADDRESS_ENTRIES; i++) begin
        if (job.kind == iprc_pkg::KIND_ADDR_WR && int'(job.entry_index) == i) begin
          addr_vld_r[i] <= job.entry_valid;
        end
      end
      for (int i = 0; i < PORT_ENTRIES; i++) begin
        if (job.kind == iprc_pkg::KIND_PORT_WR && int'(job.entry_index) == i) begin
          port_vld_r[i] <= job.entry_valid;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      for (int i = 0; i < ADDRESS_ENTRIES; i++) begin
        if (job.kind == iprc_pkg::KIND_ADDR_WR && int'(job.entry_index) == i) begin
          addr_key_r[i] <= job.entry_key;
        end
      end
      for (int i = 0; i < PORT_ENTRIES; i++) begin
        if (job.kind == iprc_pkg::KIND_PORT_WR && int'(job.entry_index) == i) begin
          port_key_r[i] <= job.entry_key;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (job_pop && is_frame) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop && is_frame) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/ipv4_port_redirect_classifier.sv
// ----------------------------------------------------------------------------
// ipv4_port_redirect_classifier
// Per-frame drop / pass / redirect verdicts from IPv4 destination address
// and TCP/UDP destination port matches.
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// in_      input      in_valid/in_stall  iprc_in_t  (frame byte or table write)
// out_     output     out_valid/out_stall iprc_out_t (one verdict per frame)
// cfg_     input      cfg_valid/cfg_ready cfg_data  (queue_ready_mask)
//
// One input item per cycle sustained while in_stall is low. A frame's last
// byte pushes its job into a four-entry job queue between parsing and matching;
// its verdict is registered on pop, and in_stall rises only when it is full.
// Synchronous reset clears all tables to invalid at once; no clearing pass.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module ipv4_port_redirect_classifier #(
  parameter int ADDRESS_ENTRIES = iprc_pkg::ADDRESS_ENTRIES_DEF,
  parameter int PORT_ENTRIES    = iprc_pkg::PORT_ENTRIES_DEF,
  parameter int QUEUE_COUNT     = iprc_pkg::QUEUE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  iprc_pkg::iprc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output iprc_pkg::iprc_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  logic                 item_acc, job_push, job_full, job_pop, job_empty;
  iprc_pkg::iprc_desc_t job_in, job_head;
  logic [15:0]          mask_r;

  assign in_stall  = job_full;
  assign item_acc  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      mask_r <= cfg_data;
    end
  end

  iprc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_acc (item_acc),
    .item     (in_data),
    .job_push (job_push),
    .job      (job_in)
  );

  iprc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .head      (job_head),
    .empty     (job_empty)
  );

  iprc_back #(
    .ADDRESS_ENTRIES (ADDRESS_ENTRIES),
    .PORT_ENTRIES    (PORT_ENTRIES),
    .QUEUE_COUNT     (QUEUE_COUNT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_empty        (job_empty),
    .job              (job_head),
    .job_pop          (job_pop),
    .queue_ready_mask (mask_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data)
  );

endmodule

>>> rtl/iprc_checker.sv
// ----------------------------------------------------------------------------
// iprc_checker
// Port-level checks for the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module iprc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input iprc_pkg::iprc_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("out item changed while stalled");

  a_queue_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.verdict != iprc_pkg::VERDICT_REDIRECT
      |-> out_data.target_queue == 4'd0)
    else $error("target_queue set on a non-redirect verdict");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind ipv4_port_redirect_classifier iprc_checker u_iprc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IPv4 port redirect classifier. A behavioral
// predictor tracks the frame parser, both match tables and the queue ready
// mask, and queues one expected verdict per frame. Directed tests walk each
// length, header and table check; random phases send mostly well-formed
// TCP/UDP frames with table churn under varying idle and stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import iprc_pkg::*;

  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam logic [15:0] ETHER_TYPE_V6  = 16'h86DD;
  localparam logic [7:0]  IHL_OK         = 8'h45;
  localparam logic [7:0]  IHL_BAD        = 8'h46;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [31:0] ADDR_A         = 32'hC0A8_0001;
  localparam logic [31:0] ADDR_B         = 32'h0A00_00FE;
  localparam logic [31:0] ADDR_MISS      = 32'h0102_0304;
  localparam logic [15:0] PORT_U         = 16'h1234;
  localparam logic [15:0] PORT_T         = 16'h0050;
  localparam int          DRAIN_CYCLES   = 12;
  localparam int          MAX_GAP        = 12;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  iprc_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  iprc_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;

  int in_pct      = 0;
  int out_pct     = 0;
  int hold_len    = 0;
  int error_cnt   = 0;
  int bytes_sent  = 0;

  // predictor state
  int          byte_pos;
  logic [15:0] cap_ether_type;
  logic        cap_ihl_ok;
  logic [31:0] cap_dest_addr;
  logic [7:0]  cap_proto;
  logic [15:0] cap_dest_port;
  logic [3:0]  cap_queue;
  logic        addr_ok  [ADDRESS_ENTRIES_DEF];
  logic [31:0] addr_key [ADDRESS_ENTRIES_DEF];
  logic        port_ok  [PORT_ENTRIES_DEF];
  logic [31:0] port_key_tab [PORT_ENTRIES_DEF];
  logic [15:0] ready_mask;
  iprc_out_t   expected_verdicts [$];

  logic [31:0] addr_pool [4];
  logic [15:0] port_pool [4];

  ipv4_port_redirect_classifier u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [31:0] port_key(logic [7:0] pr, logic [15:0] port);
    return {port, 8'h00, pr};
  endfunction

  function automatic bit table_has(bit port_sel, logic [31:0] key);
    if (port_sel) begin
      for (int i = 0; i < PORT_ENTRIES_DEF; i++)
        if (port_ok[i] && port_key_tab[i] == key) return 1'b1;
    end else begin
      for (int i = 0; i < ADDRESS_ENTRIES_DEF; i++)
        if (addr_ok[i] && addr_key[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void clear_frame();
    byte_pos       = 0;
    cap_ether_type = '0;
    cap_ihl_ok     = 1'b0;
    cap_dest_addr  = '0;
    cap_proto      = '0;
    cap_dest_port  = '0;
    cap_queue      = '0;
  endfunction

  // update predictor with one accepted item; queue a verdict on a last byte
  function automatic void classify_item(iprc_in_t it);
    int        len;
    iprc_out_t res;
    case (it.op)
      OP_ADDR_WR: begin
        if (it.entry_index < ADDRESS_ENTRIES_DEF) begin
          addr_ok[it.entry_index]  = it.entry_valid;
          addr_key[it.entry_index] = it.entry_key;
        end
      end
      OP_PORT_WR: begin
        if (it.entry_index < PORT_ENTRIES_DEF) begin
          port_ok[it.entry_index]      = it.entry_valid;
          port_key_tab[it.entry_index] = it.entry_key;
        end
      end
      OP_BYTE: begin
        if (byte_pos == 0) cap_queue = it.rx_queue;
        case (byte_pos)
          12: cap_ether_type[15:8] = it.data_byte;
          13: cap_ether_type[7:0]  = it.data_byte;
          14: cap_ihl_ok           = (it.data_byte[3:0] == 4'd5);
          23: cap_proto            = it.data_byte;
          30: cap_dest_addr[7:0]   = it.data_byte;
          31: cap_dest_addr[15:8]  = it.data_byte;
          32: cap_dest_addr[23:16] = it.data_byte;
          33: cap_dest_addr[31:24] = it.data_byte;
          36: cap_dest_port[7:0]   = it.data_byte;
          37: cap_dest_port[15:8]  = it.data_byte;
          default: ;
        endcase
        len = byte_pos + 1;
        if (byte_pos < 63) byte_pos++;
        if (it.last_byte) begin
          if (len < 14)
            res.verdict = VERDICT_DROP;
          else if (cap_ether_type != ETHER_TYPE_IPV4)
            res.verdict = VERDICT_PASS;
          else if (len < 34 || !cap_ihl_ok)
            res.verdict = VERDICT_DROP;
          else if (!table_has(1'b0, cap_dest_addr))
            res.verdict = VERDICT_PASS;
          else if (cap_proto != PROTO_TCP && cap_proto != PROTO_UDP)
            res.verdict = VERDICT_PASS;
          else if ((cap_proto == PROTO_TCP && len < 54) ||
                   (cap_proto == PROTO_UDP && len < 42))
            res.verdict = VERDICT_DROP;
          else if (!table_has(1'b1, port_key(cap_proto, cap_dest_port)))
            res.verdict = VERDICT_PASS;
          else if (cap_queue < QUEUE_COUNT_DEF && ready_mask[cap_queue])
            res.verdict = VERDICT_REDIRECT;
          else
            res.verdict = VERDICT_DROP;
          res.target_queue = (res.verdict == VERDICT_REDIRECT) ? cap_queue : 4'd0;
          expected_verdicts.push_back(res);
          clear_frame();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic iprc_in_t rnd_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(iprc_in_t)-1:0];
  endfunction

  function automatic iprc_in_t table_item(logic [1:0] op, logic [3:0] idx,
                                          logic [31:0] key, logic vld);
    iprc_in_t it;
    it             = rnd_item();
    it.op          = op;
    it.entry_index = idx;
    it.entry_key   = key;
    it.entry_valid = vld;
    return it;
  endfunction

  function automatic iprc_in_t random_table_item();
    logic [31:0] r;
    logic [31:0] key;
    int          k;
    r = $urandom;
    k = $urandom_range(0, 3);
    if (r[4]) key = port_key((k < 2) ? PROTO_TCP : PROTO_UDP, port_pool[k]);
    else      key = addr_pool[k];
    if ($urandom_range(0, 99) < 20) key = $urandom;
    return table_item(r[4] ? OP_PORT_WR : OP_ADDR_WR, r[3:0], key,
                      $urandom_range(0, 99) < 80);
  endfunction

  task automatic send_item(input iprc_in_t it);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < in_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    classify_item(it);
  endtask

  task automatic send_frame(input int len, input logic [15:0] et, input logic [7:0] b14,
                            input logic [7:0] pr, input logic [31:0] da,
                            input logic [15:0] dp, input logic [3:0] q,
                            input int inj_at, input iprc_in_t inj);
    iprc_in_t it;
    for (int i = 0; i < len; i++) begin
      if (i == inj_at) send_item(inj);
      it    = rnd_item();
      it.op = OP_BYTE;
      case (i)
        12: it.data_byte = et[15:8];
        13: it.data_byte = et[7:0];
        14: it.data_byte = b14;
        23: it.data_byte = pr;
        30: it.data_byte = da[7:0];
        31: it.data_byte = da[15:8];
        32: it.data_byte = da[23:16];
        33: it.data_byte = da[31:24];
        36: it.data_byte = dp[7:0];
        37: it.data_byte = dp[15:8];
        default: ;
      endcase
      it.last_byte = (i == len - 1);
      if (i == 0) it.rx_queue = q;
      send_item(it);
      bytes_sent++;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_ready_mask(input logic [15:0] m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    ready_mask  = m;
    @(posedge clk);
  endtask

  // receiver: check each accepted verdict, then pick next stall
  always @(posedge clk) begin : verdict_check
    iprc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        error_cnt++;
        if (error_cnt <= 10)
          $display("unexpected verdict %0d queue %0d", out_data.verdict,
                   out_data.target_queue);
      end else begin
        want = expected_verdicts.pop_front();
        if (out_data.verdict !== want.verdict ||
            out_data.target_queue !== want.target_queue) begin
          error_cnt++;
          if (error_cnt <= 10)
            $display("verdict mismatch: expected %0d/q%0d got %0d/q%0d", want.verdict,
                     want.target_queue, out_data.verdict, out_data.target_queue);
        end
      end
    end
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len = hold_len - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < out_pct);
    end
  end

  task automatic test_table_load();
    write_ready_mask(16'hFFFF);
    send_item(table_item(OP_ADDR_WR, 4'd0, ADDR_A, 1'b1));
    send_item(table_item(OP_ADDR_WR, 4'd15, ADDR_B, 1'b1));
    send_item(table_item(OP_PORT_WR, 4'd0, port_key(PROTO_UDP, PORT_U), 1'b1));
    send_item(table_item(OP_PORT_WR, 4'd15, port_key(PROTO_TCP, PORT_T), 1'b1));
  endtask

  task automatic test_length_checks();
    send_frame(1, ETHER_TYPE_IPV4, IHL_OK, PROTO_UDP, ADDR_A, PORT_U, 4'd1, -1, '0);
    send_frame(13, ETHER_TYPE_IPV4, IHL_OK, PROTO_UDP, ADDR_A, PORT_U, 4'd1, -1, '0);
    send_frame(14, ETHER_TYPE_V6, IHL_OK, PROTO_UDP, ADDR_A, PORT_U, 4'd1, -1, '0);
    send_frame(14, ETHER_TYPE_IPV4, IHL_OK, PROTO_UDP, ADDR_A, PORT_U, 4'd1, -1, '0);
    send_frame(33, ETHER_TYPE_IPV4, IHL_OK, PROTO_UDP, ADDR_A, PORT_U, 4'd1, -1, '0);
  endtask

  task automatic test_header_checks();
    send_frame(34, ETHER_TYPE_IPV4, IHL_BAD, PROTO_UDP, ADDR_A, PORT_U, 4'd2, -1, '0);
    send_frame(34, ETHER_TYPE_IPV4, IHL_OK, PROTO_UDP, ADDR_MISS, PORT_U, 4'd2, -1, '0);
    send_frame(34, ETHER_TYPE_IPV4, IHL_OK, PROTO_UDP, ADDR_A, PORT_U, 4'd2, -1, '0);
    send_frame(41, ETHER_TYPE_IPV4, IHL_OK, PROTO_UDP, ADDR_A, PORT_U, 4'd2, -1, '0);
    send_frame(54, ETHER_TYPE_IPV4, IHL_OK, PROTO_ICMP, ADDR_A, PORT_U, 4'd2, -1, '0);
  endtask

  task automatic test_port_match();
    iprc_in_t noise;
    send_frame(42, ETHER_TYPE_IPV4, IHL_OK, PROTO_UDP, ADDR_A, PORT_U, 4'd3, -1, '0);
    send_frame(53, ETHER_TYPE_IPV4, IHL_OK, PROTO_TCP, ADDR_B, PORT_T, 4'd15, -1, '0);
    send_frame(54, ETHER_TYPE_IPV4, IHL_OK, PROTO_TCP, ADDR_B, PORT_T, 4'd15, -1, '0);
    send_frame(54, ETHER_TYPE_IPV4, IHL_OK, PROTO_TCP, ADDR_B, PORT_U, 4'd15, -1, '0);
    send_frame(42, ETHER_TYPE_IPV4, IHL_OK, PROTO_UDP, ADDR_A, PORT_T, 4'd3, -1, '0);
    // long frame: offset saturates, fields still captured
    send_frame(72, ETHER_TYPE_IPV4, IHL_OK, PROTO_TCP, ADDR_B, PORT_T, 4'd0, -1, '0);
    noise           = rnd_item();
    noise.op        = OP_UNUSED;
    noise.last_byte = 1'b1;
    send_item(noise);
  endtask

  task automatic test_mid_frame_writes();
    send_frame(42, ETHER_TYPE_IPV4, IHL_OK, PROTO_UDP, ADDR_A, PORT_U, 4'd2, 20,
               table_item(OP_ADDR_WR, 4'd0, ADDR_A, 1'b0));
    send_frame(42, ETHER_TYPE_IPV4, IHL_OK, PROTO_UDP, ADDR_A, PORT_U, 4'd2, 41,
               table_item(OP_ADDR_WR, 4'd7, ADDR_A, 1'b1));
    // duplicate key survives clearing of the other slot
    send_item(table_item(OP_ADDR_WR, 4'd9, ADDR_B, 1'b1));
    send_frame(54, ETHER_TYPE_IPV4, IHL_OK, PROTO_TCP, ADDR_B, PORT_T, 4'd6, 10,
               table_item(OP_ADDR_WR, 4'd15, ADDR_B, 1'b0));
    send_frame(54, ETHER_TYPE_IPV4, IHL_OK, PROTO_TCP, ADDR_B, PORT_T, 4'd6, 30,
               table_item(OP_PORT_WR, 4'd15, port_key(PROTO_TCP, PORT_T), 1'b0));
    send_item(table_item(OP_PORT_WR, 4'd15, port_key(PROTO_TCP, PORT_T), 1'b1));
  endtask

  task automatic test_queue_mask();
    wait_idle();
    write_ready_mask(16'h0000);
    send_frame(42, ETHER_TYPE_IPV4, IHL_OK, PROTO_UDP, ADDR_A, PORT_U, 4'd3, -1, '0);
    wait_idle();
    write_ready_mask(16'h0020);
    send_frame(42, ETHER_TYPE_IPV4, IHL_OK, PROTO_UDP, ADDR_A, PORT_U, 4'd5, -1, '0);
    send_frame(42, ETHER_TYPE_IPV4, IHL_OK, PROTO_UDP, ADDR_A, PORT_U, 4'd4, -1, '0);
    wait_idle();
    write_ready_mask(16'hFFFF);
  endtask

  // receiver holds off while short frames keep coming; job queue fills
  task automatic test_backpressure();
    hold_len = 300;
    for (int i = 0; i < 30; i++) begin
      if (i % 5 == 4)
        send_frame(14, ETHER_TYPE_V6, IHL_OK, PROTO_TCP, ADDR_B, PORT_T, 4'd1, -1, '0);
      else
        send_frame(1, ETHER_TYPE_IPV4, IHL_OK, PROTO_TCP, ADDR_B, PORT_T, 4'd1, -1, '0);
    end
    send_item(table_item(OP_PORT_WR, 4'd15, port_key(PROTO_TCP, PORT_T), 1'b1));
    wait_idle();
  endtask

  task automatic test_random(input int sender_pct, input int receiver_pct, input int n_bytes,
                             input logic [15:0] mask_a, input logic [15:0] mask_b);
    logic [31:0] r;
    logic [15:0] et;
    logic [7:0]  b14;
    logic [7:0]  pr;
    logic [31:0] da;
    logic [15:0] dp;
    int          len;
    int          sel;
    int          inj_at;
    int          frames;
    int          start;
    bit          switched;
    iprc_in_t    inj;
    in_pct  = sender_pct;
    out_pct = receiver_pct;
    write_ready_mask(mask_a);
    for (int i = 0; i < 4; i++) begin
      addr_pool[i] = $urandom;
      r            = $urandom;
      port_pool[i] = r[15:0];
    end
    for (int i = 0; i < 4; i++) begin
      r = $urandom;
      send_item(table_item(OP_ADDR_WR, r[3:0], addr_pool[i], 1'b1));
      send_item(table_item(OP_PORT_WR, r[7:4],
                           port_key((i < 2) ? PROTO_TCP : PROTO_UDP, port_pool[i]), 1'b1));
    end
    frames   = 0;
    start    = bytes_sent;
    switched = 1'b0;
    while (bytes_sent - start < n_bytes || frames < 4) begin
      if (!switched && bytes_sent - start >= n_bytes / 2) begin
        wait_idle();
        write_ready_mask(mask_b);
        switched = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        send_item(random_table_item());
      end else if (sel < 8) begin
        inj    = rnd_item();
        inj.op = OP_UNUSED;
        send_item(inj);
      end else begin
        r   = $urandom;
        sel = $urandom_range(0, 99);
        pr  = (sel < 45) ? PROTO_TCP : (sel < 85) ? PROTO_UDP : r[7:0];
        if (pr == PROTO_TCP)      len = $urandom_range(50, 63);
        else if (pr == PROTO_UDP) len = $urandom_range(38, 48);
        else                      len = $urandom_range(30, 56);
        if ($urandom_range(0, 99) < 8) len = $urandom_range(64, 72);
        et  = ETHER_TYPE_IPV4;
        b14 = {r[11:8], 4'h5};
        da  = addr_pool[$urandom_range(0, 3)];
        dp  = port_pool[$urandom_range(0, 3)];
        r   = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 8)       len = $urandom_range(1, 33);
        else if (sel < 12) et  = r[15:0];
        else if (sel < 16) b14 = r[23:16];
        else if (sel < 22) da  = $urandom;
        else if (sel < 28) dp  = r[31:16];
        inj_at = -1;
        inj    = '0;
        if ($urandom_range(0, 99) < 10) begin
          inj_at = $urandom_range(0, len - 1);
          if ($urandom_range(0, 99) < 85) begin
            inj = random_table_item();
          end else begin
            inj    = rnd_item();
            inj.op = OP_UNUSED;
          end
        end
        r = $urandom;
        send_frame(len, et, b14, pr, da, dp, r[3:0], inj_at, inj);
        frames++;
      end
    end
    wait_idle();
  endtask

  initial begin
    logic [31:0] seed_mask;
    for (int i = 0; i < ADDRESS_ENTRIES_DEF; i++) begin
      addr_ok[i]  = 1'b0;
      addr_key[i] = '0;
    end
    for (int i = 0; i < PORT_ENTRIES_DEF; i++) begin
      port_ok[i]      = 1'b0;
      port_key_tab[i] = '0;
    end
    ready_mask = '0;
    clear_frame();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_load();
    test_length_checks();
    test_header_checks();
    test_port_match();
    test_mid_frame_writes();
    test_queue_mask();
    test_backpressure();
    seed_mask = $urandom;
    test_random(18, 54, 240, seed_mask[15:0], 16'hFFFF);
    seed_mask = $urandom;
    test_random(54, 18, 240, 16'h0000, seed_mask[15:0]);
    seed_mask = $urandom;
    test_random(0, 0, 240, seed_mask[31:16], 16'h8001);

    wait_idle();
    if (error_cnt == 0 && expected_verdicts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
